FILE: rtl/core/fct_pkg.sv
package fct_pkg;

    localparam int unsigned NumPlanesDefault  = 6;
    localparam int unsigned CoordWidthDefault = 32;
    localparam int unsigned CoefWidth         = 32;
    localparam int unsigned CoefsPerPlane     = 4;
    localparam int unsigned FracBits          = 16;
    localparam int unsigned RadiusWidth       = 31;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_POINT   = 3'd1,
        OP_SPHERE  = 3'd2,
        OP_BOX_IN  = 3'd3,
        OP_BOX_HIT = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        COEF_A = 2'd0,
        COEF_B = 2'd1,
        COEF_C = 2'd2,
        COEF_D = 2'd3
    } t_coef;

    typedef logic signed [CoefWidth-1:0] t_coef_word;

endpackage

FILE: rtl/core/fct_if.sv
interface fct_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [2:0]  plane_index;
    logic [1:0]  coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] x_low;
    logic signed [31:0] y_low;
    logic signed [31:0] z_low;
    logic signed [31:0] x_high;
    logic signed [31:0] y_high;
    logic signed [31:0] z_high;
    logic [30:0] sphere_radius;

    modport source (
        output valid, opcode, plane_index, coef_index, coef_value,
               x_low, y_low, z_low, x_high, y_high, z_high, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, opcode, plane_index, coef_index, coef_value,
               x_low, y_low, z_low, x_high, y_high, z_high, sphere_radius,
        output ready
    );
endinterface

interface fct_out_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

FILE: rtl/core/fct_coef_store.sv
module fct_coef_store
    import fct_pkg::*;
#(
    parameter int unsigned NUM_PLANES = NumPlanesDefault
) (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic       i_wr,
    input  logic [2:0] i_plane,
    input  logic [1:0] i_coef,
    input  t_coef_word i_value,
    output t_coef_word o_coef [NUM_PLANES][CoefsPerPlane]
);

    localparam int unsigned PIW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    t_coef_word r_mem [NUM_PLANES][CoefsPerPlane];
    logic       wr_ok;
    logic [PIW-1:0] wr_plane;

    // planes beyond the configured count are silently dropped
    assign wr_ok    = i_wr && ({2'b00, i_plane} < 5'(NUM_PLANES));
    assign wr_plane = PIW'(i_plane);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_plane][i_coef] <= i_value;
        end
    end

    // snapshot taken as the item moves on, before any later write lands
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_coef <= r_mem;
        end
    end

endmodule

FILE: rtl/core/fct_plane_unit.sv
module fct_plane_unit
    import fct_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  t_op                           i_op,
    input  t_coef_word                    i_a,
    input  t_coef_word                    i_b,
    input  t_coef_word                    i_c,
    input  t_coef_word                    i_d,
    input  logic signed [COORD_WIDTH-1:0] i_x_lo,
    input  logic signed [COORD_WIDTH-1:0] i_y_lo,
    input  logic signed [COORD_WIDTH-1:0] i_z_lo,
    input  logic signed [COORD_WIDTH-1:0] i_x_hi,
    input  logic signed [COORD_WIDTH-1:0] i_y_hi,
    input  logic signed [COORD_WIDTH-1:0] i_z_hi,
    input  logic [RadiusWidth-1:0]        i_radius,
    output logic                          o_pos
);

    localparam int unsigned PW = CoefWidth + COORD_WIDTH;
    localparam int unsigned SW = PW + 3;
    localparam int unsigned DW = CoefWidth + FracBits;

    logic signed [COORD_WIDTH-1:0] sel_x, sel_y, sel_z;
    logic signed [DW-1:0]          d_term;
    logic signed [SW-1:0]          bias;
    logic signed [SW-1:0]          sum;

    logic signed [PW-1:0] r_pa, r_pb, r_pc;
    logic signed [SW-1:0] r_db;
    logic signed [SW-1:0] r_s1, r_s2;

    // box tests use the one corner that is extreme along the normal:
    // nearest for fully inside, farthest for intersects; low and high may
    // come swapped, so the larger of the two is found by compare
    function automatic logic pick_hi(input t_op op, input logic neg, input logic swap);
        logic r;
        case (op)
            OP_BOX_IN:  r = neg ^ swap;
            OP_BOX_HIT: r = !neg ^ swap;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb begin
        sel_x  = pick_hi(i_op, i_a[CoefWidth-1], i_x_hi < i_x_lo) ? i_x_hi : i_x_lo;
        sel_y  = pick_hi(i_op, i_b[CoefWidth-1], i_y_hi < i_y_lo) ? i_y_hi : i_y_lo;
        sel_z  = pick_hi(i_op, i_c[CoefWidth-1], i_z_hi < i_z_lo) ? i_z_hi : i_z_lo;
        d_term = signed'({i_d, FracBits'(0)});
        bias   = (i_op == OP_SPHERE)
               ? signed'(SW'({i_radius, FracBits'(0)})) : '0;
        sum    = r_s1 + r_s2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa  <= i_a * sel_x;
            r_pb  <= i_b * sel_y;
            r_pc  <= i_c * sel_z;
            r_db  <= SW'(d_term) + bias;
            r_s1  <= SW'(r_pa) + SW'(r_pb);
            r_s2  <= SW'(r_pc) + r_db;
            o_pos <= !sum[SW-1] && (sum != '0);
        end
    end

endmodule

FILE: rtl/core/frustum_cull_tester_core.sv
// Culling tester for NUM_PLANES planes, six by default. Opcode 0 writes one
// plane coefficient (a, b, c or d, signed Q16.16) and gives no result;
// opcodes 1 to 4 test a point, a sphere, a box for full containment or a box
// for intersection against all planes and give one visible beat each; other
// opcodes are consumed and give nothing. A plane must be fully written before
// it is tested. The pipeline takes one beat per clock while the output is not
// stalled; a beat passes through two payload stages, the per-plane multiply,
// the adder level, the final sum with its sign test and the and across
// planes, all stepped by one shared enable so a stalled output holds every
// stage. Box tests use only the extreme corner per plane.
module frustum_cull_tester_core
    import fct_pkg::*;
#(
    parameter int unsigned NUM_PLANES  = NumPlanesDefault,
    parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fct_in_if.sink    i_in,
    fct_out_if.source o_out
);

    localparam int unsigned CW = COORD_WIDTH;

    logic en;
    logic acc;
    logic is_test;
    t_op  in_op;

    t_coef_word coef [NUM_PLANES][CoefsPerPlane];
    logic [NUM_PLANES-1:0] pos;

    logic r_va, r_vb, r_vc, r_vd, r_ve, r_out_valid;
    logic r_out_visible;
    t_op  r_op_a, r_op_b;
    logic signed [CW-1:0] r_a_xl, r_a_yl, r_a_zl, r_a_xh, r_a_yh, r_a_zh;
    logic signed [CW-1:0] r_b_xl, r_b_yl, r_b_zl, r_b_xh, r_b_yh, r_b_zh;
    logic [RadiusWidth-1:0] r_rad_a, r_rad_b;

    assign en          = !r_out_valid || o_out.ready;
    assign i_in.ready  = en;
    assign acc         = i_in.valid && en;
    assign in_op       = t_op'(i_in.opcode);
    assign o_out.valid = r_out_valid;
    assign o_out.visible = r_out_visible;

    always_comb begin
        case (in_op)
            OP_POINT, OP_SPHERE, OP_BOX_IN, OP_BOX_HIT: is_test = 1'b1;
            default:                                    is_test = 1'b0;
        endcase
    end

    fct_coef_store #(.NUM_PLANES(NUM_PLANES)) u_store (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_wr    (acc && (in_op == OP_WRITE)),
        .i_plane (i_in.plane_index),
        .i_coef  (i_in.coef_index),
        .i_value (i_in.coef_value),
        .o_coef  (coef)
    );

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fct_plane_unit #(.COORD_WIDTH(CW)) u_plane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_op     (r_op_b),
            .i_a      (coef[p][COEF_A]),
            .i_b      (coef[p][COEF_B]),
            .i_c      (coef[p][COEF_C]),
            .i_d      (coef[p][COEF_D]),
            .i_x_lo   (r_b_xl),
            .i_y_lo   (r_b_yl),
            .i_z_lo   (r_b_zl),
            .i_x_hi   (r_b_xh),
            .i_y_hi   (r_b_yh),
            .i_z_hi   (r_b_zh),
            .i_radius (r_rad_b),
            .o_pos    (pos[p])
        );
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op_a  <= in_op;
            r_a_xl  <= i_in.x_low[CW-1:0];
            r_a_yl  <= i_in.y_low[CW-1:0];
            r_a_zl  <= i_in.z_low[CW-1:0];
            r_a_xh  <= i_in.x_high[CW-1:0];
            r_a_yh  <= i_in.y_high[CW-1:0];
            r_a_zh  <= i_in.z_high[CW-1:0];
            r_rad_a <= i_in.sphere_radius;
            r_op_b  <= r_op_a;
            r_b_xl  <= r_a_xl;
            r_b_yl  <= r_a_yl;
            r_b_zl  <= r_a_zl;
            r_b_xh  <= r_a_xh;
            r_b_yh  <= r_a_yh;
            r_b_zh  <= r_a_zh;
            r_rad_b <= r_rad_a;
            r_out_visible <= &pos;
        end
    end

    // valid bits for test beats only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_vc        <= 1'b0;
            r_vd        <= 1'b0;
            r_ve        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_va        <= acc && is_test;
            r_vb        <= r_va;
            r_vc        <= r_vb;
            r_vd        <= r_vc;
            r_ve        <= r_vd;
            r_out_valid <= r_ve;
        end
    end

endmodule
